// ===== rtl/core/tcpq_pkg.sv =====
// Package for the two-class priority queue: codes, field widths and the
// command type that links the controller to the datapath.
// Used by tcpq_ctrl, tcpq_dp and two_class_priority_queue.
`timescale 1ns / 1ps

package tcpq_pkg;

   // Field widths fixed by the item format
   localparam int TICKET_W = 16;
   localparam int AGE_W    = 8;
   localparam int STATUS_W = 2;

   // Threshold value after reset
   localparam logic [AGE_W-1:0] THRESHOLD_RESET = 8'd60;

   // Action codes of an input item
   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_SERVE   = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_ENQUEUED = 2'd0,
      STAT_DROPPED  = 2'd1,
      STAT_SERVED   = 2'd2,
      STAT_EMPTY    = 2'd3
   } status_type;

   // Source of the ticket in a pending result
   typedef enum logic [1:0] {
      SRC_NONE   = 2'd0,
      SRC_HIGH   = 2'd1,
      SRC_NORMAL = 2'd2
   } src_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;   // take the input item and update the queues
      logic unload;    // the result register is being emptied
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic threshold_busy;   // a threshold write is happening this cycle
   } stat_type;

endpackage

// ===== rtl/core/two_class_priority_queue.sv =====
// Two-class priority queue: a high-priority and a normal ticket FIFO with
// strict-priority service. The result is registered: it shows in the cycle
// after capture. Throughput: one item per cycle while results are taken,
// set by the single result register, which takes a new item only in the
// cycle its result leaves; a threshold write holds off items for its cycle.
// Reset: synchronous, active high; both queues empty, threshold back to 60.
`timescale 1ns / 1ps

module two_class_priority_queue #(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // Input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] ticket_in, [23:16] age_in
   input  logic        req_tuser,   // [0] action
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] ticket_out
   output logic [2:0]  rsp_tuser,   // [1:0] status, [2] from_high
   // Threshold register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // [7:0] priority_age_threshold
);

   tcpq_pkg::cmd_type  dp_cmd;
   tcpq_pkg::stat_type dp_stat;
   logic [tcpq_pkg::STATUS_W-1:0] rsp_status;
   logic                          rsp_from_high;

   // Threshold writes are always taken
   assign csr_ready = 1'b1;

   tcpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_stat    (dp_stat),
      .dp_cmd     (dp_cmd)
   );

   tcpq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .dp_cmd        (dp_cmd),
      .dp_stat       (dp_stat),
      .csr_valid     (csr_valid),
      .csr_data      (csr_data),
      .req_action    (req_tuser),
      .req_ticket    (req_tdata[15:0]),
      .req_age       (req_tdata[23:16]),
      .rsp_status    (rsp_status),
      .rsp_ticket    (rsp_tdata),
      .rsp_from_high (rsp_from_high)
   );

   assign rsp_tuser = {rsp_from_high, rsp_status};

endmodule

// ===== rtl/core/tcpq_ctrl.sv =====
// Controller for the two-class priority queue: a one-hot state machine
// that runs the input and result handshakes. Depends on tcpq_pkg.
`timescale 1ns / 1ps

module tcpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  tcpq_pkg::stat_type dp_stat,
   output tcpq_pkg::cmd_type  dp_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_OUT  = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Handshake outputs; in ST_OUT a new item enters when the result leaves
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = ~dp_stat.threshold_busy;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            req_tready = rsp_tready & ~dp_stat.threshold_busy;
         end
         default: begin
            req_tready = 1'b0;
            rsp_tvalid = 1'b0;
         end
      endcase
   end

   assign dp_cmd.capture = req_tvalid & req_tready;
   assign dp_cmd.unload  = rsp_tvalid & rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (dp_cmd.capture) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (dp_cmd.capture)     state_in = ST_OUT;
            else if (dp_cmd.unload) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/tcpq_dp.sv =====
// Datapath for the two-class priority queue: threshold register, the two
// ticket memories with their pointers and counts, and the result register.
// Depends on tcpq_pkg.
`timescale 1ns / 1ps

module tcpq_dp #(
   parameter int DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tcpq_pkg::cmd_type              dp_cmd,
   output tcpq_pkg::stat_type             dp_stat,
   input  logic                           csr_valid,
   input  logic [tcpq_pkg::AGE_W-1:0]     csr_data,
   input  logic                           req_action,
   input  logic [tcpq_pkg::TICKET_W-1:0]  req_ticket,
   input  logic [tcpq_pkg::AGE_W-1:0]     req_age,
   output logic [tcpq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [tcpq_pkg::TICKET_W-1:0]  rsp_ticket,
   output logic                           rsp_from_high
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   // Threshold register
   logic [tcpq_pkg::AGE_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= tcpq_pkg::THRESHOLD_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // Hold off items in the cycle the threshold changes
   assign dp_stat.threshold_busy = csr_valid;

   // Queue pointers and counts
   logic [AW-1:0] hi_head_ff, hi_head_in, hi_tail_ff, hi_tail_in;
   logic [AW-1:0] nm_head_ff, nm_head_in, nm_tail_ff, nm_tail_in;
   logic [CW-1:0] hi_cnt_ff, hi_cnt_in, nm_cnt_ff, nm_cnt_in;

   logic hi_wr, nm_wr, hi_rd, nm_rd;
   logic hi_sel;

   tcpq_pkg::status_type status_in;
   logic                 from_high_in;
   tcpq_pkg::src_type    src_in;

   assign hi_sel = (req_age >= thr_ff);

   // Decide the operation for the item being captured
   always_comb begin
      hi_head_in   = hi_head_ff;
      hi_tail_in   = hi_tail_ff;
      hi_cnt_in    = hi_cnt_ff;
      nm_head_in   = nm_head_ff;
      nm_tail_in   = nm_tail_ff;
      nm_cnt_in    = nm_cnt_ff;
      hi_wr        = 1'b0;
      nm_wr        = 1'b0;
      hi_rd        = 1'b0;
      nm_rd        = 1'b0;
      status_in    = tcpq_pkg::STAT_EMPTY;
      from_high_in = 1'b0;
      src_in       = tcpq_pkg::SRC_NONE;
      if (req_action == tcpq_pkg::ACT_ENQUEUE) begin
         from_high_in = hi_sel;
         if (hi_sel) begin
            if (hi_cnt_ff == FULL_CNT) begin
               status_in = tcpq_pkg::STAT_DROPPED;
            end else begin
               status_in  = tcpq_pkg::STAT_ENQUEUED;
               hi_wr      = 1'b1;
               hi_tail_in = (hi_tail_ff == LAST_IDX) ? '0 : hi_tail_ff + 1'b1;
               hi_cnt_in  = hi_cnt_ff + 1'b1;
            end
         end else begin
            if (nm_cnt_ff == FULL_CNT) begin
               status_in = tcpq_pkg::STAT_DROPPED;
            end else begin
               status_in  = tcpq_pkg::STAT_ENQUEUED;
               nm_wr      = 1'b1;
               nm_tail_in = (nm_tail_ff == LAST_IDX) ? '0 : nm_tail_ff + 1'b1;
               nm_cnt_in  = nm_cnt_ff + 1'b1;
            end
         end
      end else if (hi_cnt_ff != '0) begin
         status_in    = tcpq_pkg::STAT_SERVED;
         from_high_in = 1'b1;
         src_in       = tcpq_pkg::SRC_HIGH;
         hi_rd        = 1'b1;
         hi_head_in   = (hi_head_ff == LAST_IDX) ? '0 : hi_head_ff + 1'b1;
         hi_cnt_in    = hi_cnt_ff - 1'b1;
      end else if (nm_cnt_ff != '0) begin
         status_in  = tcpq_pkg::STAT_SERVED;
         src_in     = tcpq_pkg::SRC_NORMAL;
         nm_rd      = 1'b1;
         nm_head_in = (nm_head_ff == LAST_IDX) ? '0 : nm_head_ff + 1'b1;
         nm_cnt_in  = nm_cnt_ff - 1'b1;
      end
   end

   // Advance pointers and counts on capture
   always_ff @(posedge clock) begin
      if (reset) begin
         hi_head_ff <= '0;
         hi_tail_ff <= '0;
         hi_cnt_ff  <= '0;
         nm_head_ff <= '0;
         nm_tail_ff <= '0;
         nm_cnt_ff  <= '0;
      end else if (dp_cmd.capture) begin
         hi_head_ff <= hi_head_in;
         hi_tail_ff <= hi_tail_in;
         hi_cnt_ff  <= hi_cnt_in;
         nm_head_ff <= nm_head_in;
         nm_tail_ff <= nm_tail_in;
         nm_cnt_ff  <= nm_cnt_in;
      end
   end

   // Ticket memories with registered read
   logic [tcpq_pkg::TICKET_W-1:0] hi_mem [DEPTH];
   logic [tcpq_pkg::TICKET_W-1:0] nm_mem [DEPTH];
   logic [tcpq_pkg::TICKET_W-1:0] hi_rd_ff, nm_rd_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.capture && hi_wr) hi_mem[hi_tail_ff] <= req_ticket;
      if (dp_cmd.capture && hi_rd) hi_rd_ff <= hi_mem[hi_head_ff];
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture && nm_wr) nm_mem[nm_tail_ff] <= req_ticket;
      if (dp_cmd.capture && nm_rd) nm_rd_ff <= nm_mem[nm_head_ff];
   end

   // Result register; held until the next capture
   tcpq_pkg::status_type status_ff;
   logic                 from_high_ff;
   tcpq_pkg::src_type    src_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         status_ff    <= status_in;
         from_high_ff <= from_high_in;
         src_ff       <= src_in;
      end
   end

   // Select the served ticket, zero otherwise
   always_comb begin
      case (src_ff)
         tcpq_pkg::SRC_HIGH:   rsp_ticket = hi_rd_ff;
         tcpq_pkg::SRC_NORMAL: rsp_ticket = nm_rd_ff;
         default:              rsp_ticket = '0;
      endcase
   end

   assign rsp_status    = status_ff;
   assign rsp_from_high = from_high_ff;

endmodule

// ===== tb/sv/ticket_queue_checker.sv =====
// Checker for the two-class priority queue: tracks both ticket FIFOs and the
// age threshold from the observed item, result and register-write handshakes.
// Depends on tcpq_pkg for widths, action and status codes.
`timescale 1ns / 1ps

module ticket_queue_checker #(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] ticket_in, [23:16] age_in
   input  logic        req_tuser,   // [0] action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [15:0] ticket_out
   input  logic [2:0]  rsp_tuser,   // [1:0] status, [2] from_high
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,    // [7:0] priority_age_threshold
   output int          error_count,
   output int          pending_count
);

   localparam int NORMAL = 0;
   localparam int HIGH   = 1;

   typedef struct {
      tcpq_pkg::status_type                status;
      logic [tcpq_pkg::TICKET_W-1:0]       ticket;
      logic                                from_high;
   } ticket_result_type;

   // Shadow copy of both FIFOs, indexed by class
   logic [tcpq_pkg::TICKET_W-1:0] class_store [2][DEPTH];
   int                            class_head  [2];
   int                            class_tail  [2];
   int                            class_count [2];
   logic [tcpq_pkg::AGE_W-1:0]    age_threshold;

   ticket_result_type             awaited_results [$];

   // Apply one item to the shadow queues and return the result it must cause
   function automatic ticket_result_type predict_ticket_result(
         logic                          act,
         logic [tcpq_pkg::TICKET_W-1:0] ticket,
         logic [tcpq_pkg::AGE_W-1:0]    age);
      ticket_result_type r;
      int                q;
      r.status    = tcpq_pkg::STAT_ENQUEUED;
      r.ticket    = '0;
      r.from_high = 1'b0;
      if (act == tcpq_pkg::ACT_ENQUEUE) begin
         r.from_high = (age >= age_threshold);
         q = r.from_high ? HIGH : NORMAL;
         if (class_count[q] == DEPTH) begin
            r.status = tcpq_pkg::STAT_DROPPED;
         end else begin
            class_store[q][class_tail[q]] = ticket;
            class_tail[q]  = (class_tail[q] + 1) % DEPTH;
            class_count[q] = class_count[q] + 1;
         end
      end else if (class_count[HIGH] == 0 && class_count[NORMAL] == 0) begin
         r.status = tcpq_pkg::STAT_EMPTY;
      end else begin
         // strict priority: high class first
         q = (class_count[HIGH] != 0) ? HIGH : NORMAL;
         r.status        = tcpq_pkg::STAT_SERVED;
         r.from_high     = (q == HIGH);
         r.ticket        = class_store[q][class_head[q]];
         class_head[q]   = (class_head[q] + 1) % DEPTH;
         class_count[q]  = class_count[q] - 1;
      end
      return r;
   endfunction

   function automatic void note_failure(string what);
      error_count = error_count + 1;
      if (error_count <= 10)
         $display("[%0t] ERROR: %s", $realtime, what);
   endfunction

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      ticket_result_type exp_r;
      if (reset) begin
         // clear shadow state
         for (int q = 0; q < 2; q++) begin
            class_head[q]  = 0;
            class_tail[q]  = 0;
            class_count[q] = 0;
         end
         age_threshold = tcpq_pkg::THRESHOLD_RESET;
         awaited_results.delete();
      end else begin
         // predict first so a same-edge result still meets the oldest entry
         if (req_tvalid && req_tready)
            awaited_results.push_back(predict_ticket_result(req_tuser, req_tdata[15:0],
                                                            req_tdata[23:16]));
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               note_failure($sformatf("unexpected result: status %0d ticket %h from_high %b",
                                      rsp_tuser[1:0], rsp_tdata, rsp_tuser[2]));
            end else begin
               exp_r = awaited_results.pop_front();
               if (rsp_tuser[1:0] !== exp_r.status || rsp_tdata !== exp_r.ticket ||
                   rsp_tuser[2] !== exp_r.from_high)
                  note_failure($sformatf({"result mismatch: expected status %0d ticket %h ",
                                          "from_high %b, got status %0d ticket %h from_high %b"},
                                         exp_r.status, exp_r.ticket, exp_r.from_high,
                                         rsp_tuser[1:0], rsp_tdata, rsp_tuser[2]));
            end
         end
         // register write takes effect for later items
         if (csr_valid && csr_ready)
            age_threshold = csr_data;
      end
      pending_count = awaited_results.size();
   end

endmodule

// ===== tb/sv/two_class_priority_queue_tb.sv =====
// Top of the two-class priority queue testbench: clock, reset, stimulus on
// the item and threshold channels, result back-pressure and the verdict.
// Depends on tcpq_pkg, two_class_priority_queue and ticket_queue_checker.
`timescale 1ns / 1ps

module two_class_priority_queue_tb;

   localparam int DEPTH       = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SEGMENT_LEN = 80;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;    // [15:0] ticket_in, [23:16] age_in
   logic        req_tuser  = 1'b0;  // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [15:0] ticket_out
   logic [2:0]  rsp_tuser;          // [1:0] status, [2] from_high
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = '0;    // [7:0] priority_age_threshold

   int                         error_count;
   int                         pending_count;
   int                         send_idle_pct = 15;
   int                         recv_idle_pct = 51;
   logic [tcpq_pkg::AGE_W-1:0] threshold_now = tcpq_pkg::THRESHOLD_RESET;

   two_class_priority_queue #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   ticket_queue_checker #(.DEPTH(DEPTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Random back-pressure on results
   initial begin
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Hard stop if the run hangs
   initial begin
      int cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
         @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   // Offer one item, with random idle cycles ahead of it, and hold until taken
   task automatic send_item(logic act, logic [tcpq_pkg::TICKET_W-1:0] ticket,
                            logic [tcpq_pkg::AGE_W-1:0] age);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {age, ticket};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and hold until every awaited result has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   task automatic write_threshold(logic [tcpq_pkg::AGE_W-1:0] value);
      wait_for_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid     <= 1'b0;
      threshold_now  = value;
   endtask

   // Ages mostly right around the threshold, sometimes anywhere
   function automatic logic [tcpq_pkg::AGE_W-1:0] pick_age();
      case ($urandom_range(3))
         0:       return threshold_now - 8'd1;
         1:       return threshold_now;
         2:       return threshold_now + 8'd1;
         default: return (tcpq_pkg::AGE_W)'($urandom_range(255));
      endcase
   endfunction

   // Bursts with varying serve rate push the queues between empty and full
   task automatic run_segment(int n_items);
      int serve_pct;
      int k;
      serve_pct = 50;
      for (k = 0; k < n_items; k++) begin
         if (k % 16 == 0)
            serve_pct = 25 + 25 * $urandom_range(2);
         if ($urandom_range(99) < 2)
            wait_for_results();
         send_item(($urandom_range(99) < serve_pct) ? tcpq_pkg::ACT_SERVE
                                                    : tcpq_pkg::ACT_ENQUEUE,
                   (tcpq_pkg::TICKET_W)'($urandom_range(16'hFFFF)), pick_age());
      end
      wait_for_results();
   endtask

   initial begin
      int thr_plan [6];
      int s;
      logic [tcpq_pkg::AGE_W-1:0] thr;
      thr_plan = '{0, 255, 60, -1, 1, 254};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty serve, threshold edges, both queues full, drain past empty
      send_item(tcpq_pkg::ACT_SERVE,   16'h0000, 8'd0);
      send_item(tcpq_pkg::ACT_ENQUEUE, 16'h0000, 8'd59);
      send_item(tcpq_pkg::ACT_ENQUEUE, 16'hFFFF, 8'd60);
      send_item(tcpq_pkg::ACT_ENQUEUE, 16'hA5A5, 8'd255);
      send_item(tcpq_pkg::ACT_ENQUEUE, 16'h5A5A, 8'd0);
      send_item(tcpq_pkg::ACT_ENQUEUE, 16'h1234, 8'd61);
      send_item(tcpq_pkg::ACT_ENQUEUE, 16'h4321, 8'd100);
      send_item(tcpq_pkg::ACT_ENQUEUE, 16'hDEAD, 8'd200);
      send_item(tcpq_pkg::ACT_ENQUEUE, 16'h0F0F, 8'd1);
      send_item(tcpq_pkg::ACT_ENQUEUE, 16'hF0F0, 8'd30);
      send_item(tcpq_pkg::ACT_ENQUEUE, 16'hBEEF, 8'd58);
      repeat (9) send_item(tcpq_pkg::ACT_SERVE, 16'hFFFF, 8'd255);

      // Random segments, each under its own threshold and idling mix
      for (s = 0; s < 6; s++) begin
         thr = (thr_plan[s] < 0) ? (tcpq_pkg::AGE_W)'($urandom_range(2, 253))
                                 : (tcpq_pkg::AGE_W)'(thr_plan[s]);
         write_threshold(thr);
         send_idle_pct = (s < 2) ? 15 : (s < 4) ? 51 : 0;
         recv_idle_pct = (s < 2) ? 51 : (s < 4) ? 15 : 0;
         run_segment(SEGMENT_LEN);
      end

      wait_for_results();
      repeat (8) @(negedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tcpq_pkg.sv
rtl/core/tcpq_ctrl.sv
rtl/core/tcpq_dp.sv
rtl/core/two_class_priority_queue.sv
tb/sv/ticket_queue_checker.sv
tb/sv/two_class_priority_queue_tb.sv
